[rtl/core/lpsh_pkg.sv]
package lpsh_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int HALF_DEPTH  = TABLE_DEPTH / 2;
    localparam int OCC_W       = $clog2(HALF_DEPTH + 1);

    // Item field widths
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 20;
    localparam int STATUS_W = 3;

    // Hash pipeline: load -> partials -> sum -> partials -> sum, then slot select
    localparam int HASH_CYCLES = 5;
    localparam int HASH_CNT_W  = $clog2(HASH_CYCLES);

    // splitmix64 constants
    localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2   = 64'h94d049bb133111eb;

    // Opcodes
    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_NEW      = 3'd2,
        ST_REPLACED = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    pos_init;
        logic    pos_inc;
        logic    rd_en;
        logic    clr_wr;
        logic    ins_new;
        logic    ins_upd;
        logic    res_set;
        status_t res_code;
        logic    res_found;
        logic    out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic match;
        logic is_insert;
        logic has_room;
        logic clr_last;
    } stat_t;

    // full 32x32 product
    function automatic logic [63:0] mul32_full(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = {32'b0, a} * {32'b0, b};
        return p;
    endfunction

    // low 32 bits of a 32x32 product
    function automatic logic [31:0] mul32_lo(logic [31:0] a, logic [31:0] b);
        logic [31:0] p;
        p = a * b;
        return p;
    endfunction

endpackage

[rtl/core/lpsh_ram.sv]
module lpsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/lpsh_ctrl.sv]
module lpsh_ctrl
    import lpsh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  cmd,
    input  stat_t st
);

    state_t                state_reg, state_next;
    logic [HASH_CNT_W-1:0] hash_cnt_reg, hash_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  hash_last;
    logic                  out_free;
    logic                  probe_end;

    assign hash_last = (hash_cnt_reg == HASH_CNT_W'(HASH_CYCLES - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign probe_end = st.empty || st.match;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_last)
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD:
            begin
                state_next = S_PROBE_CMP;
            end
            S_PROBE_CMP:
            begin
                state_next = probe_end ? S_DONE : S_PROBE_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.res_code = ST_HIT;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            S_IDLE:
            begin
                cmd.load = in_valid;
            end
            S_HASH:
            begin
                cmd.pos_init = hash_last;
            end
            S_PROBE_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_PROBE_CMP:
            begin
                if (st.empty)
                begin
                    cmd.res_set = 1'b1;
                    if (st.is_insert && st.has_room)
                    begin
                        cmd.ins_new  = 1'b1;
                        cmd.res_code = ST_NEW;
                    end
                    else if (st.is_insert)
                    begin
                        cmd.res_code = ST_FULL;
                    end
                    else
                    begin
                        cmd.res_code = ST_MISS;
                    end
                end
                else if (st.match)
                begin
                    cmd.res_set = 1'b1;
                    if (st.is_insert)
                    begin
                        cmd.ins_upd  = 1'b1;
                        cmd.res_code = ST_REPLACED;
                    end
                    else
                    begin
                        cmd.res_code  = ST_HIT;
                        cmd.res_found = 1'b1;
                    end
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.res_code = ST_HIT;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        hash_cnt_next = (state_reg == S_HASH) ? hash_cnt_reg + 1'b1 : '0;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hash_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_cnt_reg  <= hash_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while previous item still pending");

    a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_HASH && hash_cnt_reg == '0))
        else $error("accepted item did not start hashing");

    a_single_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !((cmd.ins_new || cmd.ins_upd) && (cmd.clr_wr || (cmd.ins_new && cmd.ins_upd))))
        else $error("conflicting table writes");

    a_result_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_set |=> (state_reg == S_DONE))
        else $error("probe ended without reaching done");

endmodule

[rtl/core/lpsh_dp.sv]
module lpsh_dp
    import lpsh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                st,
    input  logic                 opcode,
    input  logic signed [31:0]   key_x,
    input  logic signed [31:0]   key_y,
    input  logic signed [15:0]   key_heading,
    input  logic signed [15:0]   key_hitch,
    input  logic [VALUE_W-1:0]   node_value,
    output logic [STATUS_W-1:0]  status,
    output logic [VALUE_W-1:0]   found_value
);

    // item registers
    logic                op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  val_reg;

    // hash pipeline
    logic [63:0] v0_reg, v0_next;
    logic [63:0] z1;
    logic [63:0] pa_ll_reg, pa_ll_next;
    logic [31:0] pa_hl_reg, pa_hl_next;
    logic [31:0] pa_lh_reg, pa_lh_next;
    logic [63:0] m1_reg, m1_next;
    logic [63:0] z2;
    logic [63:0] pb_ll_reg, pb_ll_next;
    logic [31:0] pb_hl_reg, pb_hl_next;
    logic [31:0] pb_lh_reg, pb_lh_next;
    logic [63:0] m2_reg, m2_next;
    logic [63:0] hash;
    logic [KEY_W-1:0] packed_key;

    // probe and table control
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;

    // results
    status_t            res_status_reg;
    logic [VALUE_W-1:0] res_found_reg;
    status_t            status_reg;
    logic [VALUE_W-1:0] found_value_reg;

    // table memories
    logic               valid_wr_en;
    logic [ADDR_W-1:0]  valid_wr_addr;
    logic [0:0]         valid_wr_data;
    logic [0:0]         valid_rd;
    logic [KEY_W-1:0]   key_rd;
    logic [VALUE_W-1:0] value_rd;

    // overlapping pack: x<<32 | y<<16 | heading<<8 | hitch
    assign packed_key = {key_x, 32'b0}
                      | {16'b0, key_y, 16'b0}
                      | {40'b0, key_heading, 8'b0}
                      | {48'b0, key_hitch};

    always_comb
    begin
        v0_next = packed_key + MIX_GOLDEN;

        z1         = v0_reg ^ (v0_reg >> 30);
        pa_ll_next = mul32_full(z1[31:0], MIX_MUL1[31:0]);
        pa_hl_next = mul32_lo(z1[63:32], MIX_MUL1[31:0]);
        pa_lh_next = mul32_lo(z1[31:0], MIX_MUL1[63:32]);
        m1_next    = pa_ll_reg + {pa_hl_reg + pa_lh_reg, 32'b0};

        z2         = m1_reg ^ (m1_reg >> 27);
        pb_ll_next = mul32_full(z2[31:0], MIX_MUL2[31:0]);
        pb_hl_next = mul32_lo(z2[63:32], MIX_MUL2[31:0]);
        pb_lh_next = mul32_lo(z2[31:0], MIX_MUL2[63:32]);
        m2_next    = pb_ll_reg + {pb_hl_reg + pb_lh_reg, 32'b0};

        hash = m2_reg ^ (m2_reg >> 31);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= packed_key;
            val_reg <= node_value;
            v0_reg  <= v0_next;
        end
        pa_ll_reg <= pa_ll_next;
        pa_hl_reg <= pa_hl_next;
        pa_lh_reg <= pa_lh_next;
        m1_reg    <= m1_next;
        pb_ll_reg <= pb_ll_next;
        pb_hl_reg <= pb_hl_next;
        pb_lh_reg <= pb_lh_next;
        m2_reg    <= m2_next;
        pos_reg   <= pos_next;
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
            res_found_reg  <= cmd.res_found ? value_rd : '0;
        end
        if (cmd.out_load)
        begin
            status_reg      <= res_status_reg;
            found_value_reg <= res_found_reg;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.pos_init)
        begin
            pos_next = hash[ADDR_W-1:0];
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos_reg + 1'b1;
        end
        clr_addr_next = cmd.clr_wr ? clr_addr_reg + 1'b1 : clr_addr_reg;
        occ_next      = cmd.ins_new ? occ_reg + 1'b1 : occ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            occ_reg      <= '0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            occ_reg      <= occ_next;
        end
    end

    assign valid_wr_en   = cmd.clr_wr || cmd.ins_new;
    assign valid_wr_addr = cmd.clr_wr ? clr_addr_reg : pos_reg;
    assign valid_wr_data = cmd.clr_wr ? 1'b0 : 1'b1;

    lpsh_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH)
    ) u_valid_ram (
        .clk     (clk),
        .wr_en   (valid_wr_en),
        .wr_addr (valid_wr_addr),
        .wr_data (valid_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (pos_reg),
        .rd_data (valid_rd)
    );

    lpsh_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (cmd.ins_new),
        .wr_addr (pos_reg),
        .wr_data (key_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (pos_reg),
        .rd_data (key_rd)
    );

    lpsh_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (cmd.ins_new || cmd.ins_upd),
        .wr_addr (pos_reg),
        .wr_data (val_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (pos_reg),
        .rd_data (value_rd)
    );

    assign st.empty     = !valid_rd[0];
    assign st.match     = (key_rd == key_reg);
    assign st.is_insert = (op_reg == OP_INSERT);
    assign st.has_room  = (occ_reg < OCC_W'(HALF_DEPTH));
    assign st.clr_last  = (clr_addr_reg == {ADDR_W{1'b1}});

    assign status      = status_reg;
    assign found_value = found_value_reg;

    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(HALF_DEPTH))
        else $error("occupied count above half the table");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_new |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("new insert not counted");

    a_pos_from_hash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pos_init |=> (pos_reg == $past(hash[ADDR_W-1:0])))
        else $error("probe did not start at the hashed slot");

endmodule

[rtl/core/linear_probe_state_hash_map_top.sv]
// Path: from item accept through the hash pipeline and k probed slots (k >= 1) to out_valid.
// One item at a time: a new item is taken only after the last one has passed the hash pipeline,
//   the read/compare loop (PROBE_RD, PROBE_CMP) on the table RAM port and S_DONE.
// A new item is accepted while a finished result still waits in the output register.
// Reset: asynchronous, active low; a clearing pass then zeroes all TABLE_DEPTH (4096)
//   entries of the valid RAM with in_ready low.
module linear_probe_state_hash_map_top
    import lpsh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // input items: find or insert
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic signed [31:0]   key_x,
    input  logic signed [31:0]   key_y,
    input  logic signed [15:0]   key_heading,
    input  logic signed [15:0]   key_hitch,
    input  logic [VALUE_W-1:0]   node_value,

    // result items
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [VALUE_W-1:0]   found_value
);

    // Controller sequences clear pass, hashing, probe loop and result hand-off.
    // Datapath holds the item, the splitmix64 pipeline (32x32 partial products,
    // one register per multiply), the probe pointer, occupancy count and the
    // three table RAMs (valid, key, value). The table never holds more than half
    // its slots, so a probe always reaches an empty slot.
    cmd_t  cmd;
    stat_t st;

    lpsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    lpsh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .opcode      (opcode),
        .key_x       (key_x),
        .key_y       (key_y),
        .key_heading (key_heading),
        .key_hitch   (key_hitch),
        .node_value  (node_value),
        .status      (status),
        .found_value (found_value)
    );

endmodule

[dv/testbench.sv]
module testbench;
    import lpsh_pkg::*;

    // Lookup key as the block sees it: raw bit patterns of the four fields.
    typedef struct packed {
        bit [31:0] x;
        bit [31:0] y;
        bit [15:0] h;
        bit [15:0] b;
    } state_key_t;

    // Scoreboard: keeps a private copy of the hash map and the results still owed.
    class lookup_scoreboard;
        bit               slot_used [TABLE_DEPTH];
        bit [KEY_W-1:0]   slot_key  [TABLE_DEPTH];
        bit [VALUE_W-1:0] slot_node [TABLE_DEPTH];
        int unsigned      occupancy;
        status_t          pending_status [$];
        bit [VALUE_W-1:0] pending_found [$];
        int unsigned      requests;
        int unsigned      results;
        int unsigned      errors;
        int unsigned      tally [5];

        function new();
            occupancy = 0;
            requests  = 0;
            results   = 0;
            errors    = 0;
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            foreach (tally[i])
                tally[i] = 0;
        endfunction

        // Fields overlap in the packed word: the OR is intended.
        function bit [KEY_W-1:0] pack_key(state_key_t k);
            return {k.x, 32'h0} | {16'h0, k.y, 16'h0} | {40'h0, k.h, 8'h0} | {48'h0, k.b};
        endfunction

        function bit [63:0] splitmix64(bit [63:0] z);
            z = z + 64'h9e37_79b9_7f4a_7c15;
            z = (z ^ (z >> 30)) * 64'hbf58_476d_1ce4_e5b9;
            z = (z ^ (z >> 27)) * 64'h94d0_49bb_1331_11eb;
            return z ^ (z >> 31);
        endfunction

        function int unsigned home_slot(state_key_t k);
            bit [63:0] digest;
            digest = splitmix64(pack_key(k));
            return 32'(digest[ADDR_W-1:0]);
        endfunction

        function bit idle();
            return pending_status.size() == 0;
        endfunction

        // Applies one accepted item to the shadow map and queues its result.
        function void note_request(bit op, state_key_t k, bit [VALUE_W-1:0] node);
            bit [KEY_W-1:0]   word;
            int unsigned      pos;
            status_t          outcome;
            bit [VALUE_W-1:0] hit_node;
            word     = pack_key(k);
            pos      = home_slot(k);
            outcome  = (op == OP_INSERT) ? ST_FULL : ST_MISS;
            hit_node = '0;
            for (int unsigned n = 0; n < TABLE_DEPTH; n++)
            begin
                if (!slot_used[pos])
                begin
                    // new key goes in only while the map is below half load
                    if (op == OP_INSERT && occupancy * 2 < TABLE_DEPTH)
                    begin
                        slot_used[pos] = 1'b1;
                        slot_key[pos]  = word;
                        slot_node[pos] = node;
                        occupancy++;
                        outcome = ST_NEW;
                    end
                    break;
                end
                if (slot_key[pos] == word)
                begin
                    if (op == OP_INSERT)
                    begin
                        slot_node[pos] = node;
                        outcome = ST_REPLACED;
                    end
                    else
                    begin
                        outcome  = ST_HIT;
                        hit_node = slot_node[pos];
                    end
                    break;
                end
                pos = (pos + 1) % TABLE_DEPTH;
            end
            pending_status = {pending_status, outcome};
            pending_found  = {pending_found, hit_node};
            tally[outcome]++;
            requests++;
        endfunction

        function void flag(string msg);
            errors++;
            $display("%0t result %0d: %s", $time, results, msg);
        endfunction

        function void check_result(logic [STATUS_W-1:0] got_status,
                                   logic [VALUE_W-1:0] got_found);
            status_t          want_status;
            bit [VALUE_W-1:0] want_found;
            results++;
            if (pending_status.size() == 0)
            begin
                flag($sformatf("unexpected result, expected none, got status %0d value 0x%05h",
                               got_status, got_found));
                return;
            end
            want_status = pending_status.pop_front();
            want_found  = pending_found.pop_front();
            if (got_status !== want_status)
                flag($sformatf("status expected %s (%0d), got %0d",
                               want_status.name(), want_status, got_status));
            if (got_found !== want_found)
                flag($sformatf("found_value expected 0x%05h, got 0x%05h",
                               want_found, got_found));
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Clock, reset, DUT
    // ---------------------------------------------------------------------
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic                opcode      = OP_FIND;
    logic signed [31:0]  key_x       = '0;
    logic signed [31:0]  key_y       = '0;
    logic signed [15:0]  key_heading = '0;
    logic signed [15:0]  key_hitch   = '0;
    logic [VALUE_W-1:0]  node_value  = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  found_value;

    always #1 clk = ~clk;

    linear_probe_state_hash_map_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key_x       (key_x),
        .key_y       (key_y),
        .key_heading (key_heading),
        .key_hitch   (key_hitch),
        .node_value  (node_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_value (found_value)
    );

    lookup_scoreboard board = new();
    state_key_t       known_keys [$];   // every key ever inserted, refused ones too
    bit               calm = 1'b1;      // when set, neither side idles
    int unsigned      ready_hold = 0;
    int unsigned      ready_gap;

    // Most gaps are short, a few are long.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Field values lean on the extremes and on small indices near the origin,
    // where planner keys live and where the packed fields alias.
    function automatic bit [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4, 5: return 32'($urandom_range(0, 63)) - 32'd32;
            default: return $urandom();
        endcase
    endfunction

    function automatic bit [15:0] pick_half();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0;
            3: return 16'hffff;
            4, 5: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic bit [VALUE_W-1:0] pick_node();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    function automatic state_key_t key_of(bit [31:0] x, bit [31:0] y, bit [15:0] h,
                                          bit [15:0] b);
        state_key_t k;
        k.x = x;
        k.y = y;
        k.h = h;
        k.b = b;
        return k;
    endfunction

    function automatic state_key_t fresh_key();
        return key_of(pick_word(), pick_word(), pick_half(), pick_half());
    endfunction

    function automatic state_key_t known_key();
        if (known_keys.size() == 0)
            return fresh_key();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    // Same packed word, different fields: shift the overlapping bits from one
    // field into its neighbor.
    function automatic state_key_t alias_key(state_key_t k);
        state_key_t a;
        a = k;
        if ($urandom_range(0, 1))
        begin
            a.x[15:0]  = k.x[15:0] | k.y[31:16];
            a.y[31:16] = '0;
            a.h[15:8]  = k.h[15:8] | k.y[7:0];
            a.y[7:0]   = '0;
            a.h[7:0]   = k.h[7:0] | k.b[15:8];
            a.b[15:8]  = '0;
        end
        else
        begin
            a.y[31:16] = k.x[15:0] | k.y[31:16];
            a.x[15:0]  = '0;
            a.y[7:0]   = k.h[15:8] | k.y[7:0];
            a.h[15:8]  = '0;
            a.b[15:8]  = k.h[7:0] | k.b[15:8];
            a.h[7:0]   = '0;
        end
        return a;
    endfunction

    // Presents one item, holds it until accepted, then maybe idles.
    task automatic send_request(bit op, state_key_t k, bit [VALUE_W-1:0] node);
        int unsigned gap;
        in_valid    <= 1'b1;
        opcode      <= op;
        key_x       <= k.x;
        key_y       <= k.y;
        key_heading <= k.h;
        key_hitch   <= k.b;
        node_value  <= node;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(op, k, node);
        if (op == OP_INSERT)
            known_keys = {known_keys, k};
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One random item: traffic on keys already in the map and on fresh keys, plus
    // aliased keys and single-bit neighbors of stored keys.
    task automatic mixed_request();
        int unsigned r;
        state_key_t  k;
        bit [95:0]   flip;
        r = $urandom_range(0, 99);
        if (r < 30)
            send_request(OP_INSERT, fresh_key(), pick_node());
        else if (r < 45)
            send_request(OP_INSERT, known_key(), pick_node());
        else if (r < 75)
            send_request(OP_FIND, known_key(), pick_node());
        else if (r < 85)
            send_request(OP_FIND, fresh_key(), pick_node());
        else if (r < 93)
            send_request(1'($urandom_range(0, 1)), alias_key(known_key()), pick_node());
        else
        begin
            flip = 96'b1 << $urandom_range(0, 95);
            k    = state_key_t'(known_key() ^ flip);
            send_request(1'($urandom_range(0, 1)), k, pick_node());
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: sample at the edge, then decide the next ready level.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(status, found_value);
        if (ready_hold > 0)
            ready_hold = ready_hold - 1;
        else if (out_ready)
        begin
            ready_gap = idle_len();
            if (ready_gap > 0)
            begin
                out_ready  <= 1'b0;
                ready_hold = ready_gap - 1;
            end
            else
                ready_hold = $urandom_range(0, 5);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold = $urandom_range(0, 7);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial
    begin
        state_key_t wrap_keys [$];
        state_key_t k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // in_ready stays low through the clearing pass; send_request waits it out.

        // Directed: empty map, insert / replace, field extremes, node extremes.
        calm = 1'b1;
        send_request(OP_FIND,   key_of(0, 0, 0, 0), '0);
        send_request(OP_INSERT, key_of(0, 0, 0, 0), '0);
        send_request(OP_FIND,   key_of(0, 0, 0, 0), '1);
        send_request(OP_INSERT, key_of(0, 0, 0, 0), '1);
        send_request(OP_FIND,   key_of(0, 0, 0, 0), '0);
        k = key_of(32'h8000_0000, 32'h7fff_ffff, 16'h8000, 16'h7fff);
        send_request(OP_INSERT, k, 20'h5a5a5);
        send_request(OP_FIND,   k, '0);
        k = key_of(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
        send_request(OP_INSERT, k, 20'ha5a5a);
        send_request(OP_FIND,   k, '0);
        send_request(OP_FIND,   key_of(32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 16'h8000), '0);

        // Overlapping fields: distinct keys that pack to the same word must hit.
        send_request(OP_INSERT, key_of(1, 0, 0, 0), 20'h00111);
        send_request(OP_FIND,   key_of(0, 32'h0001_0000, 0, 0), '0);
        send_request(OP_INSERT, key_of(0, 0, 16'h0001, 0), 20'h00222);
        send_request(OP_FIND,   key_of(0, 0, 0, 16'h0100), '0);
        send_request(OP_INSERT, key_of(0, 1, 0, 0), 20'h00333);
        send_request(OP_FIND,   key_of(0, 0, 16'h0100, 0), '0);

        // Probe wrap: keys whose first slot is the last one in the map, so a
        // collision chain runs past the end back to slot zero.
        while (wrap_keys.size() < 4)
        begin
            k = key_of($urandom(), $urandom(), 16'($urandom()), 16'($urandom()));
            if (board.home_slot(k) == TABLE_DEPTH - 1)
                wrap_keys = {wrap_keys, k};
        end
        send_request(OP_INSERT, wrap_keys[0], pick_node());
        send_request(OP_INSERT, wrap_keys[1], pick_node());
        send_request(OP_INSERT, wrap_keys[2], pick_node());
        send_request(OP_FIND,   wrap_keys[2], '0);
        send_request(OP_FIND,   wrap_keys[3], '0);

        // Random mix, with a quiet stretch every fourth block of items.
        for (int i = 0; i < 980; i++)
        begin
            calm = ((i / 128) % 4) == 3;
            mixed_request();
        end

        // Tail: idling on both sides, then back to back to the end.
        for (int i = 0; i < 100; i++)
        begin
            calm = (i >= 70);
            mixed_request();
        end

        in_valid <= 1'b0;
        calm = 1'b1;
        while (!board.idle())
            @(posedge clk);
        // catch any stray result after the last one owed
        repeat (64) @(posedge clk);

        $display("Applied %0d items: %0d hits, %0d misses, %0d new, %0d replaced, %0d refused",
                 board.requests, board.tally[ST_HIT], board.tally[ST_MISS],
                 board.tally[ST_NEW], board.tally[ST_REPLACED], board.tally[ST_FULL]);
        $display("Map ended with %0d of %0d slots in use; %0d results checked, %0d errors",
                 board.occupancy, TABLE_DEPTH, board.results, board.errors);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
